### rtl/glcm_pkg.sv
// Package for the gray-level co-occurrence matrix unit.
// Holds the command codes, register indexes, state type and the control structs.
// No dependencies.
package glcm_pkg;

    localparam int CMD_W   = 2;
    localparam int PIXEL_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACCUM = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_command;

    typedef enum logic {
        CFG_SKIP_BLACK = 1'b0,
        CFG_QUARTER    = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic capture;
        logic clr_wr;
        logic inc_wr;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic out_full;
        logic clr_last;
    } t_dp_status;

endpackage

### rtl/glcm_ctrl.sv
// Controller state machine of the co-occurrence matrix unit.
// Sequences clearing sweeps, counter reads and the read-modify-write of one counter.
// Depends on glcm_pkg.
module glcm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    input  glcm_pkg::t_command   i_command,
    input  glcm_pkg::t_dp_status i_status,
    output logic                 o_s_ready,
    output glcm_pkg::t_dp_cmd    o_cmd
);

    glcm_pkg::t_state r_state, n_state;
    logic             r_is_read, n_is_read;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= glcm_pkg::ST_CLEAR;
            r_is_read <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_read <= n_is_read;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_is_read = r_is_read;
        o_s_ready = 1'b0;
        o_cmd     = '0;
        unique case (r_state)
            glcm_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = glcm_pkg::ST_IDLE;
                end
            end
            glcm_pkg::ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_command)
                        glcm_pkg::CMD_ACCUM: begin
                            n_is_read = 1'b0;
                            if (!i_status.skip) begin
                                n_state = glcm_pkg::ST_FETCH;
                            end
                        end
                        glcm_pkg::CMD_READ: begin
                            n_is_read = 1'b1;
                            n_state   = glcm_pkg::ST_FETCH;
                        end
                        glcm_pkg::CMD_CLEAR: begin
                            n_state = glcm_pkg::ST_CLEAR;
                        end
                        default: begin
                            n_state = glcm_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            glcm_pkg::ST_FETCH: begin
                n_state = glcm_pkg::ST_UPDATE;
            end
            glcm_pkg::ST_UPDATE: begin
                if (!r_is_read) begin
                    o_cmd.inc_wr = 1'b1;
                    n_state      = glcm_pkg::ST_IDLE;
                end else if (!i_status.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = glcm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = glcm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/glcm_dp.sv
// Datapath of the co-occurrence matrix unit: level quantisation, counter store,
// saturating increment, clearing sweep address, configuration and output register.
// Depends on glcm_pkg.
module glcm_dp #(
    parameter int LEVEL_BITS = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  glcm_pkg::t_cfg_index         i_cfg_index,
    input  logic                         i_cfg_data,
    input  glcm_pkg::t_command           i_command,
    input  logic [glcm_pkg::PIXEL_W-1:0] i_ref_pixel,
    input  logic [glcm_pkg::PIXEL_W-1:0] i_neighbour_pixel,
    input  logic [glcm_pkg::PIXEL_W-1:0] i_bin_row,
    input  logic [glcm_pkg::PIXEL_W-1:0] i_bin_col,
    input  glcm_pkg::t_dp_cmd            i_cmd,
    input  logic                         i_m_ready,
    output glcm_pkg::t_dp_status         o_status,
    output logic                         o_m_valid,
    output logic [COUNT_BITS-1:0]        o_bin_count
);

    localparam int ADDR_BITS = 2 * LEVEL_BITS;
    localparam int DEPTH     = 1 << ADDR_BITS;
    localparam int EXT_W     = LEVEL_BITS + glcm_pkg::PIXEL_W;

    logic [COUNT_BITS-1:0]        r_mem [DEPTH];
    logic [COUNT_BITS-1:0]        r_rdata;
    logic [ADDR_BITS-1:0]         r_addr, n_addr;
    logic [ADDR_BITS-1:0]         r_clr_addr;
    logic                         r_skip_black;
    logic                         r_quarter;
    logic                         r_out_valid;
    logic [COUNT_BITS-1:0]        r_out_data;

    logic [glcm_pkg::PIXEL_W-1:0] ref_q, nb_q;
    logic [EXT_W-1:0]             ref_ext, nb_ext, row_ext, col_ext;
    logic [LEVEL_BITS-1:0]        ref_lv, nb_lv, row_lv, col_lv;
    logic [COUNT_BITS-1:0]        inc_count;
    logic                         wr_en;
    logic [ADDR_BITS-1:0]         wr_addr;
    logic [COUNT_BITS-1:0]        wr_data;

    always_comb begin
        ref_q   = r_quarter ? {2'b00, i_ref_pixel[glcm_pkg::PIXEL_W-1:2]} : i_ref_pixel;
        nb_q    = r_quarter ? {2'b00, i_neighbour_pixel[glcm_pkg::PIXEL_W-1:2]}
                            : i_neighbour_pixel;
        ref_ext = {{LEVEL_BITS{1'b0}}, ref_q};
        nb_ext  = {{LEVEL_BITS{1'b0}}, nb_q};
        row_ext = {{LEVEL_BITS{1'b0}}, i_bin_row};
        col_ext = {{LEVEL_BITS{1'b0}}, i_bin_col};
        ref_lv  = ref_ext[LEVEL_BITS-1:0];
        nb_lv   = nb_ext[LEVEL_BITS-1:0];
        row_lv  = row_ext[LEVEL_BITS-1:0];
        col_lv  = col_ext[LEVEL_BITS-1:0];
        n_addr  = (i_command == glcm_pkg::CMD_READ) ? {row_lv, col_lv} : {ref_lv, nb_lv};
    end

    assign inc_count = (r_rdata == {COUNT_BITS{1'b1}}) ? r_rdata
                                                       : r_rdata + COUNT_BITS'(1);
    assign wr_en   = i_cmd.clr_wr | i_cmd.inc_wr;
    assign wr_addr = i_cmd.clr_wr ? r_clr_addr : r_addr;
    assign wr_data = i_cmd.clr_wr ? '0 : inc_count;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr <= n_addr;
        end
        if (i_cmd.load_out) begin
            r_out_data <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_skip_black <= 1'b0;
            r_quarter    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + ADDR_BITS'(1);
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    glcm_pkg::CFG_SKIP_BLACK: r_skip_black <= i_cfg_data;
                    glcm_pkg::CFG_QUARTER:    r_quarter    <= i_cfg_data;
                    default:                  r_quarter    <= r_quarter;
                endcase
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.skip     = r_skip_black & ((ref_lv == '0) | (nb_lv == '0));
    assign o_status.out_full = r_out_valid;
    assign o_status.clr_last = (r_clr_addr == {ADDR_BITS{1'b1}});
    assign o_m_valid         = r_out_valid;
    assign o_bin_count       = r_out_data;

endmodule

### rtl/glcm_pair_histogram_unit.sv
// Gray-level co-occurrence matrix unit: top level joining controller and datapath.
// An accumulate or a read passes through accept, fetch and update, as the read-modify-write
// of the counter store is registered; a skipped pair or an unused command ends in the accept.
// A read result is loaded into the output register in update; a read waits while the output is held.
// A clear is the accept, then a sweep of the whole store with one counter cleared a cycle.
// Reset is synchronous, active low, and runs the same sweep; depends on glcm_pkg, ctrl and dp.
module glcm_pair_histogram_unit #(
    parameter int LEVEL_BITS = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic                                   i_cfg_index,
    input  logic                                   i_cfg_data,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // command[1:0], ref_pixel[9:2], neighbour_pixel[17:10], bin_row[25:18],
    // bin_col[33:26], zero padding[39:34]
    input  logic [39:0]                            i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // bin_count[COUNT_BITS-1:0], zero padding above
    output logic [((COUNT_BITS + 7) / 8) * 8 - 1:0] o_m_axis_tdata
);

    localparam int OUT_W = ((COUNT_BITS + 7) / 8) * 8;

    glcm_pkg::t_command   command;
    glcm_pkg::t_dp_cmd    dp_cmd;
    glcm_pkg::t_dp_status dp_status;
    logic [COUNT_BITS-1:0] bin_count;

    assign command        = glcm_pkg::t_command'(i_s_axis_tdata[1:0]);
    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = OUT_W'(bin_count);

    glcm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_command (command),
        .i_status  (dp_status),
        .o_s_ready (o_s_axis_tready),
        .o_cmd     (dp_cmd)
    );

    glcm_dp #(
        .LEVEL_BITS (LEVEL_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (glcm_pkg::t_cfg_index'(i_cfg_index)),
        .i_cfg_data        (i_cfg_data),
        .i_command         (command),
        .i_ref_pixel       (i_s_axis_tdata[9:2]),
        .i_neighbour_pixel (i_s_axis_tdata[17:10]),
        .i_bin_row         (i_s_axis_tdata[25:18]),
        .i_bin_col         (i_s_axis_tdata[33:26]),
        .i_cmd             (dp_cmd),
        .i_m_ready         (i_m_axis_tready),
        .o_status          (dp_status),
        .o_m_valid         (o_m_axis_tvalid),
        .o_bin_count       (bin_count)
    );

endmodule
